/* hw/rtl/life_pkg.sv */
package life_pkg;

  // Grid geometry. The sizes derived below come from these two; item field widths are fixed.
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 128;

  // A grid column is stored as one word that covers all pages of that column.
  localparam int PAGES  = (GRID_ROWS + 7) / 8;
  localparam int WORD_W = PAGES * 8;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int STEP_W = $clog2(GRID_COLS + 3);

  // B3/S23 neighbor counts.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Command codes, echoed back as the result kind.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] write_data;
  } life_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] read_data;
  } life_out_t;

  // Controls shared by every cell of the row.
  typedef struct packed {
    logic clear;
    logic shift;
  } life_ctl_t;

endpackage

/* hw/rtl/life_automaton_step_core.sv */
// Channel   Handshake              Payload     Moves
// cmd       cmd_valid, cmd_stall   cmd_item    one command item into the block
// rsp       rsp_valid, rsp_stall   rsp_item    one result item per command
//
// A write or an unused command is answered from the idle state, a read goes
// through the read state for the registered memory word, and a generation
// streams one grid column per cycle through the single read port of the
// column memory. After reset the block clears the memory column by column and
// stalls the command channel meanwhile. One item is worked on at a time. A
// stalled result waits in the output register and holds off the next item.
module life_automaton_step_core import life_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  life_in_t  cmd_item,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output life_out_t rsp_item
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_GEN   = 2'd3;

  // The grid is held column by column: word c has bit r set when cell (r, c)
  // lives, so byte p of the word is grid byte [p][c].
  logic [WORD_W-1:0] mem [GRID_COLS];
  logic [WORD_W-1:0] rd_word;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [2:0]        page;
  logic              in_range;

  logic              cmd_accept;
  logic              cmd_in_range;
  logic [COL_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PAGES-1:0]  wr_be;
  logic [COL_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic              rsp_load;
  life_out_t         rsp_load_item;
  logic [7:0]        read_byte;

  life_ctl_t         ctl;
  logic [WORD_W-1:0] col_in;
  logic [WORD_W-1:0] col_next;

  assign cmd_stall    = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign cmd_accept   = cmd_valid && !cmd_stall;
  assign cmd_in_range = (32'(cmd_item.page) < 32'(PAGES))
                     && (32'(cmd_item.column) < 32'(GRID_COLS));

  // Column memory with one write port (byte lanes) and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < PAGES; i++) begin
        if (wr_be[i]) begin
          mem[wr_addr][i*8 +: 8] <= wr_word[i*8 +: 8];
        end
      end
    end
    rd_word <= mem[rd_addr];
  end

  // During a generation the step counter runs from 0 to GRID_COLS + 2. Column
  // s is read in step s, shifted into the cells in step s + 1, and its new
  // value is written in step s + 3, once its right neighbor sits in the row.
  // The write always trails the reads, so in-place update is safe.
  assign ctl.clear = cmd_accept && (cmd_item.cmd == CMD_STEP);
  assign ctl.shift = (state == S_GEN) && (step != '0)
                  && (step <= STEP_W'(GRID_COLS + 1));
  assign col_in    = (step <= STEP_W'(GRID_COLS)) ? rd_word : '0;

  life_cell_row u_row (
    .clk      (clk),
    .ctl      (ctl),
    .col_in   (col_in),
    .col_next (col_next)
  );

  always_comb begin
    read_byte = '0;
    for (int i = 0; i < PAGES; i++) begin
      if (32'(page) == 32'(i)) begin
        read_byte = rd_word[i*8 +: 8];
      end
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    rd_addr       = COL_W'(cmd_item.column);
    wr_en         = 1'b0;
    wr_be         = '0;
    wr_addr       = COL_W'(cmd_item.column);
    wr_word       = {PAGES{cmd_item.write_data}};
    rsp_load      = 1'b0;
    rsp_load_item = '{result_kind: cmd_item.cmd, read_data: 8'd0};

    unique case (state)
      S_CLEAR: begin
        // Zero one column per cycle after reset.
        wr_en   = 1'b1;
        wr_be   = '1;
        wr_addr = COL_W'(step);
        wr_word = '0;
        step_next = step + 1'b1;
        if (step == STEP_W'(GRID_COLS - 1)) begin
          state_next = S_IDLE;
          step_next  = '0;
        end
      end
      S_IDLE: begin
        if (cmd_accept) begin
          unique case (cmd_item.cmd)
            CMD_WRITE: begin
              for (int i = 0; i < PAGES; i++) begin
                wr_be[i] = (32'(cmd_item.page) == 32'(i));
              end
              wr_en    = cmd_in_range;
              rsp_load = 1'b1;
            end
            CMD_READ: begin
              state_next = S_READ;
            end
            CMD_STEP: begin
              state_next = S_GEN;
              step_next  = '0;
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rsp_load      = 1'b1;
        rsp_load_item = '{result_kind: CMD_READ, read_data: in_range ? read_byte : 8'd0};
        state_next    = S_IDLE;
      end
      S_GEN: begin
        rd_addr   = COL_W'(step);
        wr_be     = '1;
        wr_addr   = COL_W'(step - STEP_W'(3));
        wr_word   = col_next;
        wr_en     = (step >= STEP_W'(3));
        step_next = step + 1'b1;
        if (step == STEP_W'(GRID_COLS + 2)) begin
          rsp_load      = 1'b1;
          rsp_load_item = '{result_kind: CMD_STEP, read_data: 8'd0};
          state_next    = S_IDLE;
          step_next     = '0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the read address details and the held result.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      page     <= cmd_item.page;
      in_range <= cmd_in_range;
    end
    if (rsp_load) begin
      rsp_item <= rsp_load_item;
    end
  end

endmodule

/* hw/rtl/life_cell.sv */
module life_cell import life_pkg::*; (
  input  logic       clk,
  input  life_ctl_t  ctl,
  input  logic       active,
  input  logic       bit_in,
  input  logic [2:0] above,
  input  logic [2:0] below,
  output logic [2:0] window,
  output logic       bit_next
);

  // window[2] is the left column, window[1] the center, window[0] the right.
  logic [2:0] win;
  logic [3:0] count;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      win <= '0;
    end else if (ctl.shift) begin
      win <= {win[1:0], bit_in};
    end
  end

  assign count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
               + 4'(below[0]) + 4'(below[1]) + 4'(below[2])
               + 4'(win[2]) + 4'(win[0]);

  // Rows past the grid keep their stored bit.
  assign bit_next = active ? ((count == BIRTH_COUNT) || (win[1] && count == SURVIVE_COUNT))
                           : win[1];
  assign window   = win;

endmodule

/* hw/rtl/life_cell_row.sv */
module life_cell_row import life_pkg::*; (
  input  logic              clk,
  input  life_ctl_t         ctl,
  input  logic [WORD_W-1:0] col_in,
  output logic [WORD_W-1:0] col_next
);

  logic [2:0] win [WORD_W];

  for (genvar r = 0; r < WORD_W; r++) begin : g_row
    localparam bit ACTIVE = (r < GRID_ROWS);
    logic [2:0] above;
    logic [2:0] below;

    // Cells off the top or bottom edge of the grid count as dead.
    if (r > 0 && r - 1 < GRID_ROWS) begin : g_above
      assign above = win[r-1];
    end else begin : g_no_above
      assign above = '0;
    end

    if (r + 1 < GRID_ROWS) begin : g_below
      assign below = win[r+1];
    end else begin : g_no_below
      assign below = '0;
    end

    life_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .active   (ACTIVE),
      .bit_in   (col_in[r]),
      .above    (above),
      .below    (below),
      .window   (win[r]),
      .bit_next (col_next[r])
    );
  end

endmodule

/* tb/tb_life_automaton_step_core.sv */
module tb_life_automaton_step_core import life_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Bytes in the packed grid: one byte per page and column.
  localparam int GRID_BYTES = PAGES * GRID_COLS;
  // Number of commands, unused ones aside, after which the stimulus stops growing.
  localparam int ITEM_TARGET = 580;
  // Settling time after the last result. A generation is the slowest command.
  localparam int DRAIN_CYCLES = GRID_COLS + 16;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  life_in_t  cmd_item;
  logic      rsp_valid;
  logic      rsp_stall;
  life_out_t rsp_item;

  life_automaton_step_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  always #5 clk = ~clk;

  // Our own copy of the cell grid, kept in step with every accepted command.
  logic [7:0] grid_model [GRID_BYTES];

  // Command items waiting to be driven, and result items still owed by the block.
  life_in_t  command_queue [$];
  life_out_t reply_queue [$];

  int command_count;
  int mismatch_count;

  // A command was accepted at the last rising edge, so the driver may move on.
  logic cmd_taken;

  int cmd_gap;
  int cmd_calm;
  int stall_hold;
  int stall_calm;
  int stall_roll;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // State of one cell in the old generation. Anything off the grid is dead,
  // which also means the grid does not wrap around at its edges.
  function automatic int cell_alive(int row, int col);
    if (row < 0 || row >= GRID_ROWS || col < 0 || col >= GRID_COLS) begin
      return 0;
    end
    return int'(grid_model[(row / 8) * GRID_COLS + col][row % 8]);
  endfunction

  // One B3/S23 generation. Every new cell is worked out from the old grid
  // into a scratch copy, and only then does the copy replace the grid. Bits
  // of the last page that lie past GRID_ROWS are carried over untouched.
  function automatic void advance_generation();
    logic [7:0] fresh [GRID_BYTES];
    int row;
    int neighbors;
    for (int p = 0; p < PAGES; p++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        fresh[p * GRID_COLS + c] = grid_model[p * GRID_COLS + c];
        for (int k = 0; k < 8; k++) begin
          row = p * 8 + k;
          if (row < GRID_ROWS) begin
            neighbors = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                  neighbors += cell_alive(row + dr, c + dc);
                end
              end
            end
            fresh[p * GRID_COLS + c][k] = (neighbors == BIRTH_COUNT) ||
                (cell_alive(row, c) == 1 && neighbors == SURVIVE_COUNT);
          end
        end
      end
    end
    grid_model = fresh;
  endfunction

  // Applies one command to the grid copy and returns the result item that the
  // block owes for it. The result always echoes the command, and read data is
  // zero except on a read that lands inside the grid.
  function automatic life_out_t apply_command(life_in_t item);
    life_out_t reply;
    logic      in_range;
    int        index;
    reply.result_kind = item.cmd;
    reply.read_data   = '0;
    in_range = (int'(item.page) < PAGES) && (int'(item.column) < GRID_COLS);
    index    = int'(item.page) * GRID_COLS + int'(item.column);
    case (item.cmd)
      CMD_WRITE: begin
        if (in_range) begin
          grid_model[index] = item.write_data;
        end
      end
      CMD_READ: begin
        if (in_range) begin
          reply.read_data = grid_model[index];
        end
      end
      CMD_STEP: begin
        advance_generation();
      end
      default: begin
        // The unused command leaves the grid alone.
      end
    endcase
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_command(logic [1:0] cmd, int page, int column, int data);
    life_in_t item;
    item.cmd        = cmd;
    item.page       = page[2:0];
    item.column     = column[6:0];
    item.write_data = data[7:0];
    command_queue.push_back(item);
    // The unused command is merely ignored, so it does not count.
    if (cmd != CMD_NONE) begin
      command_count++;
    end
  endtask

  // Written bytes are often thinned out, since a dense grid mostly dies of
  // overcrowding in one generation and tells little about the rule.
  function automatic int pattern_byte();
    int roll;
    roll = $urandom_range(0, 5);
    if (roll <= 2) begin
      return $urandom_range(0, 255);
    end
    if (roll <= 4) begin
      return $urandom_range(0, 255) & $urandom_range(0, 255);
    end
    return $urandom_range(0, 1) ? 'hFF : 'h00;
  endfunction

  // A small patch of live cells is written, then evolved for a few
  // generations, and after each one the bytes in and around the patch are
  // read back. The patch sits against a grid edge now and then, and it often
  // spans two pages so that neighbors are counted across a page boundary.
  task automatic add_pattern_run();
    int base_page;
    int base_col;
    int span;
    int page;
    int col;
    span      = $urandom_range(2, 6);
    base_page = $urandom_range(0, PAGES - 1);
    base_col  = $urandom_range(0, GRID_COLS - span);
    if ($urandom_range(0, 4) == 0) begin
      base_page = $urandom_range(0, 1) ? 0 : PAGES - 1;
    end
    if ($urandom_range(0, 4) == 0) begin
      base_col = $urandom_range(0, 1) ? 0 : GRID_COLS - span;
    end
    for (int i = 0; i < span; i++) begin
      push_command(CMD_WRITE, base_page, base_col + i, pattern_byte());
      if (base_page + 1 < PAGES && $urandom_range(0, 2) == 0) begin
        push_command(CMD_WRITE, base_page + 1, base_col + i, pattern_byte());
      end
    end
    repeat ($urandom_range(1, 3)) begin
      // The address and data fields of a generation do not matter, so they
      // carry random values.
      push_command(CMD_STEP, $urandom_range(0, 7), $urandom_range(0, 127),
                   $urandom_range(0, 255));
      repeat ($urandom_range(3, 6)) begin
        page = base_page + $urandom_range(0, 2) - 1;
        col  = base_col + $urandom_range(0, span + 1) - 1;
        page = (page < 0) ? 0 : (page >= PAGES) ? PAGES - 1 : page;
        col  = (col < 0) ? 0 : (col >= GRID_COLS) ? GRID_COLS - 1 : col;
        push_command(CMD_READ, page, col, $urandom_range(0, 255));
      end
    end
  endtask

  task automatic build_stimulus();
    // Field extremes: the four grid corners, all-ones and all-zeros data.
    push_command(CMD_WRITE, 0, 0, 'hFF);
    push_command(CMD_WRITE, PAGES - 1, GRID_COLS - 1, 'hFF);
    push_command(CMD_WRITE, 0, GRID_COLS - 1, 'h81);
    push_command(CMD_WRITE, PAGES - 1, 0, 'h00);
    push_command(CMD_READ, 0, 0, 'h00);
    push_command(CMD_READ, PAGES - 1, GRID_COLS - 1, 'hFF);
    push_command(CMD_READ, 0, GRID_COLS - 1, 'h00);
    push_command(CMD_READ, PAGES - 1, 0, 'h00);
    // The unused command must not write, even with every field set.
    push_command(CMD_NONE, 5, 99, 'hA5);
    push_command(CMD_NONE, 7, 127, 'hFF);
    push_command(CMD_READ, 5, 99, 'h00);
    push_command(CMD_READ, 7, 127, 'h00);
    // A vertical blinker on rows 31 to 33 straddles pages 3 and 4. One
    // generation turns it horizontal on row 32; a second turns it back.
    push_command(CMD_WRITE, 3, 10, 'h80);
    push_command(CMD_WRITE, 4, 10, 'h03);
    push_command(CMD_STEP, 0, 0, 'h00);
    push_command(CMD_READ, 4, 9, 'h00);
    push_command(CMD_READ, 4, 10, 'h00);
    push_command(CMD_READ, 4, 11, 'h00);
    push_command(CMD_READ, 3, 10, 'h00);
    push_command(CMD_STEP, 7, 127, 'hFF);
    push_command(CMD_READ, 3, 10, 'h00);
    push_command(CMD_READ, 0, 0, 'h00);
    push_command(CMD_READ, PAGES - 1, GRID_COLS - 1, 'h00);

    // Mostly evolving patches, with scattered commands of any kind between.
    while (command_count < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 75) begin
        add_pattern_run();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_command(2'($urandom_range(CMD_WRITE, CMD_NONE)), $urandom_range(0, 7),
                       $urandom_range(0, 127), $urandom_range(0, 255));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake timing
  // ---------------------------------------------------------------------------

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_delay();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return $urandom_range(0, 2);
    end
    if (roll < 90) begin
      return $urandom_range(3, 8);
    end
    if (roll < 98) begin
      return $urandom_range(10, 30);
    end
    return $urandom_range(40, 90);
  endfunction

  // Command driver. A new item goes out once the previous one has been
  // accepted and its gap has run out; an item that is not yet accepted holds
  // its payload. Now and then a run of items goes out with no gaps at all.
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_valid <= 1'b0;
      end else if (command_queue.size() != 0) begin
        cmd_item  <= command_queue.pop_front();
        cmd_valid <= 1'b1;
        if (cmd_calm > 0) begin
          cmd_calm--;
          cmd_gap = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          cmd_calm = $urandom_range(10, 60);
          cmd_gap  = 0;
        end else begin
          cmd_gap = pick_delay();
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result stall. It is chosen cycle by cycle with no regard to the block's
  // state, so stalls land on every phase of a generation as well as on reads
  // and writes, with occasional long stretches of no stall.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
      rsp_stall <= 1'b1;
    end else if (stall_calm > 0) begin
      stall_calm--;
      rsp_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 2) begin
        stall_calm = $urandom_range(40, 250);
        rsp_stall <= 1'b0;
      end else if (stall_roll < 30) begin
        stall_hold = pick_delay();
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Monitor for both channels. The result side is checked before the command
  // accepted at the same edge is predicted, so a result can only ever match an
  // expectation from an earlier command.
  always @(posedge clk) begin
    life_out_t awaited;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (reply_queue.size() == 0) begin
        $display("%0t ns: result item with none expected: kind %0d data 0x%02h",
                 $time, rsp_item.result_kind, rsp_item.read_data);
        mismatch_count++;
      end else begin
        awaited = reply_queue.pop_front();
        if (rsp_item.result_kind !== awaited.result_kind) begin
          $display("%0t ns: result_kind expected %0d, got %0d",
                   $time, awaited.result_kind, rsp_item.result_kind);
          mismatch_count++;
        end
        if (rsp_item.read_data !== awaited.read_data) begin
          $display("%0t ns: read_data expected 0x%02h, got 0x%02h",
                   $time, awaited.read_data, rsp_item.read_data);
          mismatch_count++;
        end
      end
    end
    cmd_taken <= !rst && cmd_valid === 1'b1 && cmd_stall === 1'b0;
    if (!rst && cmd_valid === 1'b1 && cmd_stall === 1'b0) begin
      reply_queue.push_back(apply_command(cmd_item));
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    cmd_valid      = 1'b0;
    cmd_item       = '0;
    rsp_stall      = 1'b0;
    cmd_taken      = 1'b0;
    cmd_gap        = 0;
    cmd_calm       = 0;
    stall_hold     = 0;
    stall_calm     = 0;
    command_count  = 0;
    mismatch_count = 0;
    foreach (grid_model[i]) begin
      grid_model[i] = '0;
    end
    build_stimulus();

    // The block clears its grid memory after reset and stalls commands
    // meanwhile, so the driver simply waits on the handshake.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every command is accepted and every result has come back,
    // then give the block time to show any stray result.
    do begin
      @(posedge clk);
    end while (command_queue.size() != 0 || cmd_valid || reply_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && reply_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog. The slowest correct run, with every item meeting the longest
  // sender gap, a full generation and the longest result stall, stays well
  // under a fifth of this.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/life_pkg.sv
hw/rtl/life_cell.sv
hw/rtl/life_cell_row.sv
hw/rtl/life_automaton_step_core.sv
tb/tb_life_automaton_step_core.sv
